// ===== rtl/assert_macros.svh =====
// Assertion macros for the execute core checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rvx_pkg.sv =====
// ----------------------------------------------------------------------------
// rvx_pkg
// Opcodes, fault and access codes and the shared-unit operation set.
// ----------------------------------------------------------------------------
`default_nettype none
package rvx_pkg;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  localparam logic [1:0] FAULT_NONE    = 2'd0;
  localparam logic [1:0] FAULT_ACCESS  = 2'd1;
  localparam logic [1:0] FAULT_ILLEGAL = 2'd2;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_SLL, ALU_SRL, ALU_SRA, ALU_SLT, ALU_SLTU,
    ALU_XOR, ALU_OR, ALU_AND, ALU_EQ
  } alu_op_t;

  typedef struct packed {
    logic [31:0] fetch_pc;
    logic [1:0]  mem_op;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic [31:0] store_data;
    logic        wb_valid;
    logic [4:0]  wb_index;
    logic [31:0] wb_value;
    logic        halted;
    logic [1:0]  fault;
  } result_t;

  typedef struct packed {
    logic        start;
    logic        is_signed;
    logic        is_div;
    logic        hi;
    logic        a_sgn;
    logic        b_sgn;
  } md_req_t;
endpackage
`default_nettype wire

// ===== rtl/rvx_alu.sv =====
// ----------------------------------------------------------------------------
// rvx_alu
// Shared add, compare, logic and shift unit used by the execute sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_alu (
  input  rvx_pkg::alu_op_t op,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic [31:0]      y
);
  import rvx_pkg::*;
  logic [4:0] sh;
  assign sh = b[4:0];
  always_comb begin
    unique case (op)
      ALU_ADD:  y = a + b;
      ALU_SUB:  y = a - b;
      ALU_SLL:  y = a << sh;
      ALU_SRL:  y = a >> sh;
      ALU_SRA:  y = 32'($signed(a) >>> sh);
      ALU_SLT:  y = {31'd0, $signed(a) < $signed(b)};
      ALU_SLTU: y = {31'd0, a < b};
      ALU_XOR:  y = a ^ b;
      ALU_OR:   y = a | b;
      ALU_AND:  y = a & b;
      ALU_EQ:   y = {31'd0, a == b};
      default:  y = a + b;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/rvx_muldiv.sv =====
// ----------------------------------------------------------------------------
// rvx_muldiv
// Radix-2 iterative multiply and divide on magnitudes, 32 steps per op.
// ----------------------------------------------------------------------------
`default_nettype none
module rvx_muldiv (
  input  logic            clk,
  input  logic            rst,
  input  rvx_pkg::md_req_t req,
  input  logic [31:0]     a,
  input  logic [31:0]     b,
  output logic            done,
  output logic [31:0]     y
);
  import rvx_pkg::*;
  logic [63:0] acc;
  logic [31:0] opb;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic        busy, is_div, hi, neg_q, neg_r, neg_p;
  logic [32:0] trial;
  logic [32:0] psum;
  logic [31:0] am, bm;
  logic [63:0] prod;

  assign am = (req.is_signed && req.a_sgn && a[31]) ? -a : a;
  assign bm = (req.is_signed && req.b_sgn && b[31]) ? -b : b;
  assign trial = {rem, acc[31]} - {1'b0, opb};
  assign psum  = {1'b0, acc[63:32]} + {1'b0, (acc[0] ? opb : 32'd0)};
  assign prod  = neg_p ? -acc : acc;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= '0;
      is_div <= req.is_div;
      hi <= req.hi;
      opb <= bm;
      rem <= '0;
      acc <= {32'd0, am};
      neg_p <= req.is_signed && ((req.a_sgn && a[31]) ^ (req.b_sgn && b[31]));
      neg_q <= req.is_signed && (a[31] ^ b[31]);
      neg_r <= req.is_signed && a[31];
    end else if (busy) begin
      if (is_div) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          acc <= {acc[62:0], 1'b1};
        end else begin
          rem <= {rem[30:0], acc[31]};
          acc <= {acc[62:0], 1'b0};
        end
      end else begin
        acc <= {psum, acc[31:1]};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    if (is_div) y = hi ? (neg_r ? -rem : rem) : (neg_q ? -acc[31:0] : acc[31:0]);
    else        y = hi ? prod[63:32] : prod[31:0];
  end
endmodule
`default_nettype wire

// ===== rtl/rv32im_execute_core.sv =====
// ----------------------------------------------------------------------------
// rv32im_execute_core
// Multicycle RV32IM execute core with a shared ALU and iterative mul/div.
// ----------------------------------------------------------------------------
// channel    dir  signals                    payload
// s_axis     in   tvalid tready tdata tuser  tuser=cmd; tdata=instr,load,err
// m_axis     out  tvalid tready tdata tuser  tuser=fault; tdata=result fields
// cfg        in   cfg_we cfg_wdata           reset_pc
// With no stall an accepted request passes through decode/read, the ALU step
// and the result register before the result is valid, and the next request is
// taken only after that result is accepted. MUL/DIV/REM also pass through the
// iterative mul/div unit. Reset clears the register file, PC, halt and pending
// access. A stalled result keeps the core busy and blocks input.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32im_execute_core #(
  parameter int NUM_REGISTERS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // instr_word, load_data, access_error
  input  logic         s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // fetch_pc mem_op mem_size mem_addr
                                       // store_data wb_valid wb_index wb_value
                                       // halted
  output logic [1:0]   m_axis_tuser    // fault
);
  import rvx_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_EXEC, S_MD, S_FIN, S_OUT} state_t;
  state_t state;

  logic [31:0] regs [NUM_REGISTERS];
  logic [31:0] pc, pend_pc;
  logic        halt;
  logic [1:0]  pend_acc;
  logic [4:0]  pend_rd;
  logic [2:0]  pend_kind;
  logic        cmd, err;
  logic [31:0] ir, ldata, ra, rb;
  result_t     res;

  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [4:0] rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  assign op = ir[6:0];
  assign rd = ir[11:7];
  assign f3 = ir[14:12];
  assign f7 = ir[31:25];
  assign imm_i = {{20{ir[31]}}, ir[31:20]};
  assign imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  assign imm_b = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
  assign imm_u = {ir[31:12], 12'd0};
  assign imm_j = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};

  function automatic logic [31:0] rdr(input logic [31:0] r [NUM_REGISTERS],
                                      input logic [4:0] i);
    logic [31:0] v;
    v = '0;
    if (i != 5'd0 && 32'(i) < NUM_REGISTERS) v = r[i[$clog2(NUM_REGISTERS)-1:0]];
    return v;
  endfunction

  logic [31:0] rs1v, rs2v;
  assign rs1v = rdr(regs, ir[19:15]);
  assign rs2v = rdr(regs, ir[24:20]);

  // decode into ALU operation and legality
  alu_op_t     aop;
  logic [31:0] aa, ab, ay;
  logic        legal, is_md;
  always_comb begin
    aop = ALU_ADD; aa = ra; ab = rb; legal = 1'b1; is_md = 1'b0;
    unique case (op)
      OP_LUI:    begin aa = 32'd0; ab = imm_u; end
      OP_AUIPC:  begin aa = pc; ab = imm_u; end
      OP_JAL:    begin aa = pc; ab = imm_j; end
      OP_JALR:   begin ab = imm_i; legal = (f3 == 3'd0); end
      OP_BRANCH: begin
        unique case (f3)
          3'd0, 3'd1: aop = ALU_EQ;
          3'd4, 3'd5: aop = ALU_SLT;
          3'd6, 3'd7: aop = ALU_SLTU;
          default: legal = 1'b0;
        endcase
      end
      OP_LOAD:  begin ab = imm_i; legal = !(f3 == 3'd3 || f3 > 3'd5); end
      OP_STORE: begin ab = imm_s; legal = (f3 <= 3'd2); end
      OP_IMM, OP_REG: begin
        if (op == OP_IMM) ab = imm_i;
        unique case (f3)
          3'd0: aop = (op == OP_REG && f7 == F7_ALT) ? ALU_SUB : ALU_ADD;
          3'd1: aop = ALU_SLL;
          3'd2: aop = ALU_SLT;
          3'd3: aop = ALU_SLTU;
          3'd4: aop = ALU_XOR;
          3'd5: aop = (f7 == F7_ALT) ? ALU_SRA : ALU_SRL;
          3'd6: aop = ALU_OR;
          default: aop = ALU_AND;
        endcase
        if (op == OP_IMM) begin
          if (f3 == 3'd1) legal = (f7 == 7'd0);
          else if (f3 == 3'd5) legal = (f7 == 7'd0 || f7 == F7_ALT);
        end else if (f7 == F7_MULDIV) begin
          is_md = 1'b1;
        end else if (f7 == F7_ALT) begin
          legal = (f3 == 3'd0 || f3 == 3'd5);
        end else begin
          legal = (f7 == 7'd0);
        end
      end
      default: legal = 1'b0;
    endcase
  end

  rvx_alu u_alu (.op(aop), .a(aa), .b(ab), .y(ay));

  md_req_t     mreq;
  logic        md_done;
  logic [31:0] md_y;
  assign mreq.start     = (state == S_DEC) && op == OP_REG && f7 == F7_MULDIV && !halt;
  assign mreq.is_div    = f3[2];
  assign mreq.is_signed = f3[2] ? !f3[0] : (f3[1:0] != 2'd3 && f3[1:0] != 2'd0);
  assign mreq.hi        = f3[2] ? f3[1] : (f3[1:0] != 2'd0);
  assign mreq.a_sgn     = 1'b1;
  assign mreq.b_sgn     = f3[2] ? 1'b1 : (f3[1:0] == 2'd1);
  // operands come straight from the register file; ra/rb load on the same edge
  rvx_muldiv u_md (.clk(clk), .rst(rst), .req(mreq), .a(rs1v), .b(rs2v),
                   .done(md_done), .y(md_y));

  logic [31:0] exres, ldv;
  logic [31:0] next_pc;
  always_comb begin
    exres = ay; next_pc = pc + 32'd4;
    unique case (op)
      OP_JAL:  begin exres = pc + 32'd4; next_pc = ay; end
      OP_JALR: begin exres = pc + 32'd4; next_pc = {ay[31:1], 1'b0}; end
      OP_BRANCH: if (ay[0] ^ f3[0]) next_pc = pc + imm_b;
      default: ;
    endcase
    if (op == OP_REG && f7 == F7_MULDIV) begin
      if (f3[2] && rb == 32'd0) exres = f3[1] ? ra : ALL_ONES;
      else if (f3[2] && !f3[0] && ra == 32'h80000000 && rb == ALL_ONES)
        exres = f3[1] ? 32'd0 : ra;
      else exres = md_y;
    end
    unique case (pend_kind)
      3'd0: ldv = {{24{ldata[7]}}, ldata[7:0]};
      3'd1: ldv = {{16{ldata[15]}}, ldata[15:0]};
      3'd4: ldv = {24'd0, ldata[7:0]};
      3'd5: ldv = {16'd0, ldata[15:0]};
      default: ldv = ldata;
    endcase
  end

  function automatic logic wr_ok(input logic [4:0] i);
    return i != 5'd0 && 32'(i) < NUM_REGISTERS;
  endfunction

  result_t res_next;
  always_comb begin
    res_next = '0;
    res_next.fetch_pc = (pend_acc != ACC_NONE) ? pend_pc : pc;
    res_next.halted = halt;
    if (!halt) begin
      if (cmd == 1'b0 && pend_acc == ACC_NONE) begin
        if (err || !legal) begin
          res_next.halted = 1'b1; res_next.fetch_pc = pc;
          res_next.fault = err ? FAULT_ACCESS : FAULT_ILLEGAL;
        end else if (op == OP_LOAD || op == OP_STORE) begin
          res_next.fetch_pc = pc + 32'd4;
          res_next.mem_op = (op == OP_LOAD) ? ACC_LOAD : ACC_STORE;
          res_next.mem_size = f3[1:0];
          res_next.mem_addr = ay;
          res_next.store_data = (op == OP_STORE) ? rb : 32'd0;
        end else begin
          res_next.fetch_pc = next_pc;
          if (op != OP_BRANCH && wr_ok(rd)) begin
            res_next.wb_valid = 1'b1; res_next.wb_index = rd; res_next.wb_value = exres;
          end
        end
      end else if (cmd == 1'b1 && pend_acc != ACC_NONE) begin
        if (err) begin
          res_next.halted = 1'b1; res_next.fetch_pc = pc;
          res_next.fault = FAULT_ACCESS;
        end else begin
          res_next.fetch_pc = pend_pc;
          if (pend_acc == ACC_LOAD && wr_ok(pend_rd)) begin
            res_next.wb_valid = 1'b1; res_next.wb_index = pend_rd;
            res_next.wb_value = ldv;
          end
        end
      end
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {5'd0, res.halted, res.wb_value, res.wb_index, res.wb_valid,
                          res.store_data, res.mem_addr, res.mem_size, res.mem_op,
                          res.fetch_pc};
  assign m_axis_tuser  = res.fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0; halt <= 1'b0; pend_acc <= ACC_NONE;
      pend_rd <= '0; pend_kind <= '0; pend_pc <= '0;
      for (int i = 0; i < NUM_REGISTERS; i++) regs[i] <= '0;
    end else if (cfg_we) begin
      pc <= cfg_wdata; halt <= 1'b0; pend_acc <= ACC_NONE;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cmd <= s_axis_tuser;
          ir <= s_axis_tdata[31:0];
          ldata <= s_axis_tdata[63:32];
          err <= s_axis_tdata[64];
          state <= S_DEC;
        end
        S_DEC: begin
          ra <= rs1v;
          rb <= rs2v;
          state <= (op == OP_REG && f7 == F7_MULDIV && cmd == 1'b0 && !halt &&
                    pend_acc == ACC_NONE && !err) ? S_MD : S_EXEC;
        end
        S_MD: if (md_done) state <= S_EXEC;
        S_EXEC: state <= S_FIN;
        S_FIN: begin
          res <= res_next;
          state <= S_OUT;
          if (!halt) begin
            if (cmd == 1'b0 && pend_acc == ACC_NONE) begin
              if (err || !legal) begin
                halt <= 1'b1;
              end else if (op == OP_LOAD || op == OP_STORE) begin
                pend_acc <= (op == OP_LOAD) ? ACC_LOAD : ACC_STORE;
                pend_rd <= rd; pend_kind <= f3; pend_pc <= pc + 32'd4;
              end else begin
                pc <= next_pc;
                if (op != OP_BRANCH && wr_ok(rd)) begin
                  regs[rd[$clog2(NUM_REGISTERS)-1:0]] <= exres;
                end
              end
            end else if (cmd == 1'b1 && pend_acc != ACC_NONE) begin
              pend_acc <= ACC_NONE;
              if (err) begin
                halt <= 1'b1;
              end else begin
                pc <= pend_pc;
                if (pend_acc == ACC_LOAD && wr_ok(pend_rd)) begin
                  regs[pend_rd[$clog2(NUM_REGISTERS)-1:0]] <= ldv;
                end
              end
            end
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rvx_checker.sv =====
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks on the execute core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module rvx_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);
  import rvx_pkg::*;
  logic faulted;
  assign faulted = m_axis_tvalid && m_axis_tuser != FAULT_NONE;

  `ASSERT_IMPL(a_fault_halts, clk, rst, faulted, m_axis_tdata[138])
  `ASSERT_IMPL(a_no_both, clk, rst, m_axis_tvalid, !s_axis_tready)
  `ASSERT_NEXT(a_req_no_out, clk, rst, s_axis_tvalid && s_axis_tready, !m_axis_tvalid)
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule

bind rv32im_execute_core rvx_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rv32im_execute_core. An in-bench instruction set
// model predicts every result. Random instruction streams with memory
// responses, faults and restarts run under random stalls on both streams.
// ----------------------------------------------------------------------------
import rvx_pkg::*;

class exec_scoreboard;
  bit [31:0] regs [32];
  bit [31:0] pc, boot_pc, acc_next;
  bit [1:0]  acc_kind;
  bit [4:0]  acc_rd;
  bit [2:0]  acc_f3;
  bit        halt;
  result_t   pending_q [$];
  int        errors, checked;

  function new();
    foreach (regs[i]) regs[i] = '0;
    pc = '0; boot_pc = '0; acc_next = '0; acc_kind = ACC_NONE;
    acc_rd = '0; acc_f3 = '0; halt = 0; errors = 0; checked = 0;
  endfunction

  function void set_boot_pc(bit [31:0] v);
    boot_pc = v; pc = v; halt = 0; acc_kind = ACC_NONE;
  endfunction

  function bit [31:0] rreg(bit [4:0] i);
    return (i == 0) ? 32'd0 : regs[i];
  endfunction

  function void wreg(bit [4:0] i, bit [31:0] v, inout result_t r);
    if (i == 0) return;
    regs[i] = v;
    r.wb_valid = 1; r.wb_index = i; r.wb_value = v;
  endfunction

  function bit alu(bit is_imm, bit [2:0] f3, bit [6:0] f7, bit [31:0] a, bit [31:0] b,
                   output bit [31:0] y);
    bit [63:0] p;
    bit [4:0] sh;
    sh = b[4:0];
    y = '0;
    if (!is_imm && f7 == F7_MULDIV) begin
      case (f3)
        3'd0: y = a * b;
        3'd1: begin p = longint'($signed(a)) * longint'($signed(b)); y = p[63:32]; end
        3'd2: begin p = longint'($signed(a)) * longint'({32'd0, b}); y = p[63:32]; end
        3'd3: begin p = {32'd0, a} * {32'd0, b}; y = p[63:32]; end
        3'd4: begin
          if (b == 0) y = ALL_ONES;
          else if (a == 32'h80000000 && b == ALL_ONES) y = a;
          else y = $signed(a) / $signed(b);
        end
        3'd5: y = (b == 0) ? ALL_ONES : a / b;
        3'd6: begin
          if (b == 0) y = a;
          else if (a == 32'h80000000 && b == ALL_ONES) y = 32'd0;
          else y = $signed(a) % $signed(b);
        end
        default: y = (b == 0) ? a : a % b;
      endcase
      return 1;
    end
    if (!is_imm) begin
      if (f7 == F7_ALT) begin
        if (f3 == 3'd0) begin y = a - b; return 1; end
        if (f3 == 3'd5) begin y = $signed(a) >>> sh; return 1; end
        return 0;
      end
      if (f7 != 0) return 0;
    end
    case (f3)
      3'd0: y = a + b;
      3'd1: begin if (is_imm && f7 != 0) return 0; y = a << sh; end
      3'd2: y = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      3'd3: y = (a < b) ? 32'd1 : 32'd0;
      3'd4: y = a ^ b;
      3'd5: begin
        if (f7 == F7_ALT && is_imm) y = $signed(a) >>> sh;
        else if (f7 == 0) y = a >> sh;
        else return 0;
      end
      3'd6: y = a | b;
      default: y = a & b;
    endcase
    return 1;
  endfunction

  function bit [1:0] execute(bit [31:0] ir, inout result_t r);
    bit [6:0] op, f7;
    bit [4:0] rd;
    bit [2:0] f3;
    bit [31:0] a, b, ii, is, ib, ij, nxt, y;
    bit take;
    op = ir[6:0]; rd = ir[11:7]; f3 = ir[14:12]; f7 = ir[31:25];
    a = rreg(ir[19:15]); b = rreg(ir[24:20]);
    ii = {{20{ir[31]}}, ir[31:20]};
    is = {{20{ir[31]}}, ir[31:25], ir[11:7]};
    ib = {{19{ir[31]}}, ir[31], ir[7], ir[30:25], ir[11:8], 1'b0};
    ij = {{11{ir[31]}}, ir[31], ir[19:12], ir[20], ir[30:21], 1'b0};
    nxt = pc + 32'd4;
    take = 0;
    case (op)
      OP_LUI:   wreg(rd, {ir[31:12], 12'd0}, r);
      OP_AUIPC: wreg(rd, pc + {ir[31:12], 12'd0}, r);
      OP_JAL: begin wreg(rd, nxt, r); nxt = pc + ij; end
      OP_JALR: begin
        if (f3 != 0) return FAULT_ILLEGAL;
        wreg(rd, nxt, r);
        nxt = (a + ii) & ~32'd1;
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: return FAULT_ILLEGAL;
        endcase
        if (take) nxt = pc + ib;
      end
      OP_LOAD, OP_STORE: begin
        if (op == OP_LOAD ? (f3 == 3 || f3 > 5) : (f3 > 2)) return FAULT_ILLEGAL;
        acc_kind = (op == OP_LOAD) ? ACC_LOAD : ACC_STORE;
        acc_rd = rd; acc_f3 = f3; acc_next = nxt;
        r.fetch_pc = nxt; r.mem_op = acc_kind; r.mem_size = f3[1:0];
        r.mem_addr = a + ((op == OP_LOAD) ? ii : is);
        r.store_data = (op == OP_STORE) ? b : 32'd0;
        return FAULT_NONE;
      end
      OP_IMM: begin
        if (!alu(1, f3, f7, a, ii, y)) return FAULT_ILLEGAL;
        wreg(rd, y, r);
      end
      OP_REG: begin
        if (!alu(0, f3, f7, a, b, y)) return FAULT_ILLEGAL;
        wreg(rd, y, r);
      end
      default: return FAULT_ILLEGAL;
    endcase
    pc = nxt;
    r.fetch_pc = nxt;
    return FAULT_NONE;
  endfunction

  function void note_request(bit cmd, bit [31:0] ir, bit [31:0] data, bit err);
    result_t r;
    bit [1:0] f;
    bit [31:0] v;
    r = '0;
    f = FAULT_NONE;
    r.fetch_pc = (acc_kind != ACC_NONE) ? acc_next : pc;
    if (!halt) begin
      if (!cmd && acc_kind == ACC_NONE) begin
        f = err ? FAULT_ACCESS : execute(ir, r);
      end else if (cmd && acc_kind != ACC_NONE) begin
        if (err) begin
          acc_kind = ACC_NONE; f = FAULT_ACCESS;
        end else begin
          if (acc_kind == ACC_LOAD) begin
            case (acc_f3)
              3'd0: v = {{24{data[7]}}, data[7:0]};
              3'd1: v = {{16{data[15]}}, data[15:0]};
              3'd4: v = {24'd0, data[7:0]};
              3'd5: v = {16'd0, data[15:0]};
              default: v = data;
            endcase
            wreg(acc_rd, v, r);
          end
          pc = acc_next; acc_kind = ACC_NONE; r.fetch_pc = pc;
        end
      end
      if (f != FAULT_NONE) begin
        halt = 1; r = '0; r.fault = f;
      end
    end
    if (halt) r.fetch_pc = pc;
    r.halted = halt;
    pending_q.push_back(r);
  endfunction

  function void cmp(string name, bit [31:0] e, bit [31:0] a);
    if (e != a) begin
      errors++;
      $error("%s: expected %h, got %h", name, e, a);
    end
  endfunction

  function void check_result(logic [143:0] d, logic [1:0] u);
    result_t e;
    if (pending_q.size() == 0) begin
      errors++;
      $error("result with nothing expected");
      return;
    end
    e = pending_q.pop_front();
    checked++;
    cmp("fetch_pc", e.fetch_pc, d[31:0]);
    cmp("mem_op", 32'(e.mem_op), 32'(d[33:32]));
    cmp("mem_size", 32'(e.mem_size), 32'(d[35:34]));
    cmp("mem_addr", e.mem_addr, d[67:36]);
    cmp("store_data", e.store_data, d[99:68]);
    cmp("wb_valid", 32'(e.wb_valid), 32'(d[100]));
    cmp("wb_index", 32'(e.wb_index), 32'(d[105:101]));
    cmp("wb_value", e.wb_value, d[137:106]);
    cmp("halted", 32'(e.halted), 32'(d[138]));
    cmp("fault", 32'(e.fault), 32'(u));
  endfunction
endclass

module tb_top;
  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [31:0]  cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata;   // instr_word, load_data, access_error
  logic         s_axis_tuser;   // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;   // fetch_pc mem_op mem_size mem_addr store_data
                                // wb_valid wb_index wb_value halted
  logic [1:0]   m_axis_tuser;   // fault

  exec_scoreboard sb;
  int n_sent, n_live, n_restart, idle_cycles;
  bit rx_on;

  rv32im_execute_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function bit [31:0] enc_r(bit [6:0] f7, bit [4:0] rs2, bit [4:0] rs1, bit [2:0] f3,
                            bit [4:0] rd, bit [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function bit [31:0] enc_i(bit [11:0] imm, bit [4:0] rs1, bit [2:0] f3, bit [4:0] rd,
                            bit [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function bit [31:0] enc_s(bit [11:0] imm, bit [4:0] rs2, bit [4:0] rs1, bit [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  task automatic send(bit cmd, bit [31:0] ir, bit [31:0] data, bit err);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {7'd0, err, data, ir};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    if (!(sb.halt || (cmd != (sb.acc_kind != ACC_NONE)))) n_live++;
    sb.note_request(cmd, ir, data, err);
    n_sent++;
  endtask

  task automatic ins(bit [31:0] ir);
    send(1'b0, ir, $urandom, 1'b0);
  endtask

  task automatic drain_and_boot(bit [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_boot_pc(v);
    n_restart++;
  endtask

  function bit [2:0] pick_f3(bit [2:0] legal [$]);
    if ($urandom_range(0, 49) == 0) return 3'($urandom_range(0, 7));
    return legal[$urandom_range(0, legal.size() - 1)];
  endfunction

  function bit [31:0] rand_instr();
    int k;
    bit [4:0] rd, rs1, rs2;
    bit [2:0] f3;
    bit [6:0] f7;
    k = $urandom_range(0, 99);
    rd = 5'($urandom); rs1 = 5'($urandom); rs2 = 5'($urandom);
    if (k < 10) return {20'($urandom_range(0, 32'hFFFFF)), rd, OP_LUI};
    if (k < 14) return {20'($urandom_range(0, 32'hFFFFF)), rd, OP_AUIPC};
    if (k < 18) return {20'($urandom_range(0, 32'hFFFFF)), rd, OP_JAL};
    if (k < 22) return enc_i(12'($urandom), rs1, pick_f3('{3'd0}), rd, OP_JALR);
    if (k < 31) return {7'($urandom_range(0, 127)), rs2, rs1, pick_f3('{0, 1, 4, 5, 6, 7}),
                        5'($urandom), OP_BRANCH};
    if (k < 42) return enc_i(12'($urandom), rs1, pick_f3('{0, 1, 2, 4, 5}), rd, OP_LOAD);
    if (k < 50) return enc_s(12'($urandom), rs2, rs1, pick_f3('{0, 1, 2}));
    if (k < 68) begin
      f3 = 3'($urandom);
      if (f3 == 3'd1 || f3 == 3'd5) begin
        f7 = (f3 == 3'd5 && $urandom_range(0, 1)) ? F7_ALT : 7'd0;
        if ($urandom_range(0, 49) == 0) f7 = 7'($urandom);
        return enc_r(f7, rs2, rs1, f3, rd, OP_IMM);
      end
      return enc_i(12'($urandom), rs1, f3, rd, OP_IMM);
    end
    if (k < 84) begin
      f3 = 3'($urandom);
      f7 = ((f3 == 3'd0 || f3 == 3'd5) && $urandom_range(0, 1)) ? F7_ALT : 7'd0;
      if ($urandom_range(0, 49) == 0) f7 = 7'($urandom);
      return enc_r(f7, rs2, rs1, f3, rd, OP_REG);
    end
    if (k < 98) return enc_r(F7_MULDIV, rs2, rs1, 3'($urandom), rd, OP_REG);
    return $urandom;
  endfunction

  // result side: random stalls, one long hold-off to back up the core
  initial begin
    int stall, held;
    held = 0;
    wait (rx_on);
    forever begin
      if (held == 0 && sb.checked >= 300) begin
        held = 1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= 3000) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit [31:0] boots [4];
    int phase_items, tail;
    bit cmd;
    boots = '{32'h0, 32'hFFFFFFFC, 32'hFFFFFFFF, 32'h80000000};
    sb = new();
    n_sent = 0; n_live = 0; n_restart = 0; idle_cycles = 0; rx_on = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    rx_on = 1;

    // corner arithmetic, x0 writes, load extension, store, access error
    ins({20'hFFFFF, 5'd1, OP_LUI});
    ins(enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM));
    ins({20'h80000, 5'd3, OP_LUI});
    ins(enc_i(12'h7FF, 5'd0, 3'd0, 5'd4, OP_IMM));
    ins(enc_r(F7_MULDIV, 5'd2, 5'd3, 3'd4, 5'd5, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd2, 5'd3, 3'd6, 5'd6, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd0, 5'd4, 3'd4, 5'd7, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd0, 5'd4, 3'd5, 5'd8, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd0, 5'd4, 3'd6, 5'd9, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd0, 5'd4, 3'd7, 5'd10, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd2, 5'd3, 3'd1, 5'd11, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd2, 5'd3, 3'd2, 5'd12, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd2, 5'd2, 3'd3, 5'd13, OP_REG));
    ins(enc_r(F7_MULDIV, 5'd3, 5'd3, 3'd0, 5'd14, OP_REG));
    ins(enc_i(12'd5, 5'd2, 3'd0, 5'd0, OP_IMM));
    ins(enc_r(F7_ALT, 5'd31, 5'd3, 3'd5, 5'd16, OP_IMM));
    ins(enc_i(12'd1, 5'd4, 3'd0, 5'd15, OP_LOAD));
    send(1'b1, '0, 32'h00000080, 1'b0);
    ins(enc_i(12'd2, 5'd4, 3'd5, 5'd16, OP_LOAD));
    send(1'b1, '0, 32'hFFFF8000, 1'b0);
    ins(enc_s(12'hFFC, 5'd2, 5'd3, 3'd2));
    send(1'b1, '0, 32'h12345678, 1'b0);
    ins(enc_i(12'd0, 5'd3, 3'd2, 5'd17, OP_LOAD));
    send(1'b1, '0, '0, 1'b1);
    ins(enc_i(12'd4, 5'd0, 3'd0, 5'd18, OP_IMM));
    drain_and_boot(32'hFFFFFFFC);
    ins(enc_r(F7_ALT, 5'd3, 5'd1, 3'd1, 5'd19, OP_IMM));
    drain_and_boot(32'h00001000);
    send(1'b0, $urandom, '0, 1'b1);

    while (n_live < 1700) begin
      drain_and_boot(($urandom_range(0, 2) == 0) ? boots[$urandom_range(0, 3)] : $urandom);
      phase_items = 0;
      tail = 0;
      while (phase_items < 200 && tail < 2) begin
        if (sb.halt) tail++;
        if (sb.acc_kind != ACC_NONE) begin
          cmd = ($urandom_range(0, 19) != 0);
          if (cmd) send(1'b1, $urandom, $urandom, $urandom_range(0, 39) == 0);
          else send(1'b0, rand_instr(), $urandom, 1'b0);
        end else if ($urandom_range(0, 39) == 0) begin
          send(1'b1, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end else begin
          send(1'b0, rand_instr(), $urandom, $urandom_range(0, 149) == 0);
        end
        phase_items++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("tb_top: %0d requests sent (%0d executed), %0d results checked",
             n_sent, n_live, sb.checked);
    $display("tb_top: %0d boot address writes, faults and restarts included", n_restart);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rvx_pkg.sv
rtl/rvx_alu.sv
rtl/rvx_muldiv.sv
rtl/rv32im_execute_core.sv
rtl/rvx_checker.sv
verif/tb_top.sv
